/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define TCW_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define TCW_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) else $error(msg);

`endif

/* design/tcw_pkg.sv */
package tcw_pkg;

   localparam int ROWS        = 25;
   localparam int LINE_STRIDE = 81;
   localparam int COLS        = LINE_STRIDE - 1;
   localparam int CELLS       = ROWS * COLS;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int COL_W       = $clog2(COLS + 1);
   localparam int ADDR_W      = $clog2(CELLS);

   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic       scrolled;
   } rsp_type;

   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // (a + b) mod ROWS for a, b below ROWS
   function automatic row_type row_wrap(row_type a, row_type b);
      logic [ROW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ROW_W + 1)'(ROWS)) begin
         s = s - (ROW_W + 1)'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic row_type row_inc(row_type a);
      return (a == row_type'(ROWS - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic addr_type cell_addr(row_type r, col_type c);
      return addr_type'(r) * addr_type'(COLS) + addr_type'(c);
   endfunction

endpackage

/* design/tcw_ram.sv */
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/text_console_writer.sv */
// Text screen of 25 rows by 80 columns with a cursor. One item is in work at a
// time: a put-char, clear or unused action has its result registered in the
// execute state, a read in a data state after the registered memory read,
// each once the output is free; the next item is taken as soon as the result
// is registered, while it waits for its own transfer. Scrolling and clearing
// need no memory pass: rows are kept as a ring with a movable top row, and a
// per-row fill count marks how many leading cells of a row hold written bytes,
// so cells past it read as spaces. No clearing pass runs after reset.
`include "assert_macros.svh"

module text_console_writer (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  tcw_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output tcw_pkg::rsp_type rsp_item
);
   import tcw_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   logic [1:0] state_ff, state_in;
   req_type    item_ff, item_in;
   col_type    col_ff, col_in;
   row_type    line_ff, line_in;
   row_type    cur_phys_ff, cur_phys_in;
   row_type    top_ff, top_in;
   col_type    cur_fill_ff, cur_fill_in;
   col_type    fill_ff [ROWS];
   col_type    fill_in [ROWS];
   logic       in_range_ff, in_range_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       rsp_free;
   logic       is_nl, is_cr, store, move, at_bottom, scroll;
   col_type    base_col, base_fill, col_n, fill_n;
   row_type    line_n, phys_n, top_n;
   logic       rd_in_range;
   row_type    rphys;
   col_type    rcol;
   logic       ram_wr_en, ram_rd_en;
   addr_type   ram_wr_addr, ram_rd_addr;
   logic [7:0] ram_rd_data;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // put-char cursor arithmetic
   always_comb begin
      is_nl     = item_ff.char_code == CH_NEWLINE;
      is_cr     = item_ff.char_code == CH_RETURN;
      store     = !is_nl && !is_cr;
      move      = is_nl || (store && (col_ff >= col_type'(COLS)));
      at_bottom = line_ff == row_type'(ROWS - 1);
      scroll    = move && at_bottom;
      line_n    = (move && !at_bottom) ? line_ff + 1'b1 : line_ff;
      phys_n    = move ? row_inc(cur_phys_ff) : cur_phys_ff;
      top_n     = scroll ? row_inc(top_ff) : top_ff;
      base_col  = move ? '0 : col_ff;
      base_fill = move ? '0 : cur_fill_ff;
      col_n     = store ? base_col + 1'b1 : '0;
      if (store && (base_col >= base_fill)) begin
         fill_n = base_col + 1'b1;
      end else begin
         fill_n = base_fill;
      end
   end

   // read lookup
   always_comb begin
      rd_in_range = (32'(item_ff.read_row) < ROWS) && (32'(item_ff.read_col) < COLS);
      rcol        = col_type'(item_ff.read_col);
      rphys       = rd_in_range ? row_wrap(row_type'(item_ff.read_row), top_ff) : '0;
      ram_rd_addr = cell_addr(rphys, rcol);
      ram_wr_addr = cell_addr(phys_n, base_col);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      cur_phys_in  = cur_phys_ff;
      top_in       = top_ff;
      cur_fill_in  = cur_fill_ff;
      fill_in      = fill_ff;
      in_range_in  = in_range_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (item_ff.action == ACT_READ) begin
               ram_rd_en   = 1'b1;
               in_range_in = rd_in_range;
               hit_in      = rcol < fill_ff[rphys];
               state_in    = S_READ;
            end else if (rsp_free) begin
               case (item_ff.action)
                  ACT_PUT: begin
                     col_in      = col_n;
                     line_in     = line_n;
                     cur_phys_in = phys_n;
                     top_in      = top_n;
                     cur_fill_in = fill_n;
                     ram_wr_en   = store;
                     // a newline into a row, or a scroll, leaves that row blank but for any wrapped character
                     if (!is_cr) begin
                        fill_in[phys_n] = fill_n;
                     end
                  end
                  ACT_CLEAR: begin
                     col_in      = '0;
                     line_in     = '0;
                     cur_phys_in = '0;
                     top_in      = '0;
                     cur_fill_in = '0;
                     for (int i = 0; i < ROWS; i++) begin
                        fill_in[i] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in       = 1'b1;
               rsp_in.cell_char   = 8'd0;
               rsp_in.cursor_col  = 7'(col_in);
               rsp_in.cursor_row  = 5'(line_in);
               rsp_in.scrolled    = (item_ff.action == ACT_PUT) && scroll;
               state_in           = S_IDLE;
            end
         end
         S_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (!in_range_ff) begin
                  rsp_in.cell_char = 8'd0;
               end else if (hit_ff) begin
                  rsp_in.cell_char = ram_rd_data;
               end else begin
                  rsp_in.cell_char = CH_SPACE;
               end
               rsp_in.cursor_col = 7'(col_ff);
               rsp_in.cursor_row = 5'(line_ff);
               rsp_in.scrolled   = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         line_ff      <= '0;
         cur_phys_ff  <= '0;
         top_ff       <= '0;
         cur_fill_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         cur_phys_ff  <= cur_phys_in;
         top_ff       <= top_in;
         cur_fill_ff  <= cur_fill_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      item_ff     <= item_in;
      in_range_ff <= in_range_in;
      hit_ff      <= hit_in;
      rsp_ff      <= rsp_in;
   end

   tcw_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (item_ff.char_code),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `TCW_ASSERT(a_phys_tracks_line, cur_phys_ff == row_wrap(line_ff, top_ff), "cursor ring row out of step")
   `TCW_ASSERT(a_col_within_fill, col_ff <= cur_fill_ff, "cursor column past row fill")
   `TCW_ASSERT(a_fill_copy_agrees, cur_fill_ff == fill_ff[cur_phys_ff], "cursor row fill copy differs")
   `TCW_ASSERT_NEXT(a_read_to_data, (state_ff == S_EXEC) && (item_ff.action == ACT_READ), state_ff == S_READ, "read skipped data phase")

endmodule

/* sim/text_console_writer_tb.sv */
`timescale 1ns / 1ps

module text_console_writer_tb;
   import tcw_pkg::*;

   class console_scoreboard;
      logic [7:0] screen [CELLS];
      int         col;
      int         row;
      rsp_type    due_reports [$];
      int         mismatches;

      function new();
         blank_all();
         mismatches = 0;
      endfunction

      function void blank_all();
         foreach (screen[i]) screen[i] = CH_SPACE;
         col = 0;
         row = 0;
      endfunction

      // returns 1 when the screen scrolled up
      function logic next_row();
         col = 0;
         row++;
         if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = CH_SPACE;
            row = ROWS - 1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function rsp_type advance_screen(req_type item);
         rsp_type r;
         r = '0;
         case (item.action)
            ACT_PUT: begin
               if (item.char_code == CH_NEWLINE) begin
                  r.scrolled = next_row();
               end else if (item.char_code == CH_RETURN) begin
                  col = 0;
               end else begin
                  // wrap pending: move down before storing
                  if (col >= COLS) r.scrolled = next_row();
                  screen[row * COLS + col] = item.char_code;
                  col++;
               end
            end
            ACT_CLEAR: begin
               blank_all();
            end
            ACT_READ: begin
               if (item.read_row < ROWS && item.read_col < COLS)
                  r.cell_char = screen[int'(item.read_row) * COLS + int'(item.read_col)];
            end
            default: begin
            end
         endcase
         r.cursor_col = 7'(col);
         r.cursor_row = 5'(row);
         return r;
      endfunction

      function void note_transfer(req_type item);
         due_reports.push_back(advance_screen(item));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_reports.size() == 0) begin
            $error("unexpected result transfer: %h", got);
            mismatches++;
            return;
         end
         want = due_reports.pop_front();
         if (got.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
            mismatches++;
         end
         if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
            mismatches++;
         end
         if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
            mismatches++;
         end
         if (got.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
            mismatches++;
         end
      endfunction
   endclass

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int PHASE_ITEMS = 140;
   localparam int CYCLE_LIMIT = 100000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   console_scoreboard board;
   int sender_idle_pct;
   int receiver_stall_pct;
   int cycles;
   int sent;

   text_console_writer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= (reset == 1'b0) && ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_item);
      if (cycles > CYCLE_LIMIT) begin
         $display("text_console_writer_tb: errors");
         $finish;
      end
   end

   // returns at the rising edge of the transfer
   task automatic send_item(input req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_transfer(item);
      sent++;
   endtask

   task automatic put_char(input logic [7:0] code);
      req_type item;
      item.action    = ACT_PUT;
      item.char_code = code;
      item.read_row  = 5'($urandom);
      item.read_col  = 7'($urandom);
      send_item(item);
   endtask

   task automatic read_cell(input logic [4:0] r, input logic [6:0] c);
      req_type item;
      item.action    = ACT_READ;
      item.char_code = 8'($urandom);
      item.read_row  = r;
      item.read_col  = c;
      send_item(item);
   endtask

   task automatic other_action(input logic [1:0] act);
      req_type item;
      item.action    = act;
      item.char_code = 8'($urandom);
      item.read_row  = 5'($urandom);
      item.read_col  = 7'($urandom);
      send_item(item);
   endtask

   task automatic random_read();
      if ($urandom_range(0, 99) < 80)
         read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
      else
         read_cell(5'($urandom), 7'($urandom));
   endtask

   // one burst of console traffic, mostly well-formed text
   task automatic emit_burst();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // a full-width line, ending near or at wrap pending
         put_char(CH_RETURN);
         n = $urandom_range(COLS - 1, COLS + 1);
         repeat (n) put_char(8'($urandom_range(33, 126)));
         case ($urandom_range(0, 2))
            0: put_char(CH_NEWLINE);
            1: put_char(CH_RETURN);
            default: put_char(8'($urandom_range(33, 126)));
         endcase
      end else if (pick < 62) begin
         n = $urandom_range(0, 4);
         repeat (n) put_char(8'($urandom_range(32, 126)));
         put_char(($urandom_range(0, 9) == 0) ? CH_RETURN : CH_NEWLINE);
      end else if (pick < 84) begin
         n = $urandom_range(1, 4);
         repeat (n) random_read();
      end else if (pick < 86) begin
         other_action(ACT_CLEAR);
      end else if (pick < 91) begin
         other_action(ACT_NONE);
      end else begin
         put_char(8'($urandom));
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_stall = 1'b0;
      cycles = 0;
      sent = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed corners
      read_cell(5'd0, 7'd0);
      put_char(8'd65);
      put_char(8'd0);
      put_char(8'd255);
      read_cell(5'd0, 7'd0);
      read_cell(5'd0, 7'd1);
      read_cell(5'd0, 7'd2);
      put_char(CH_RETURN);
      put_char(8'd66);
      put_char(CH_NEWLINE);
      put_char(8'd127);
      read_cell(5'd0, 7'd0);
      read_cell(5'd1, 7'd0);
      read_cell(5'(ROWS - 1), 7'(COLS - 1));
      read_cell(5'(ROWS), 7'd0);
      read_cell(5'd0, 7'(COLS));
      read_cell(5'h1f, 7'h7f);
      other_action(ACT_NONE);
      other_action(ACT_CLEAR);
      read_cell(5'd0, 7'd0);
      put_char(CH_NEWLINE);
      put_char(CH_RETURN);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
            default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
         endcase
         n_loop: while (sent < 21 + (phase + 1) * PHASE_ITEMS) emit_burst();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.due_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (board.mismatches == 0) begin
         $display("text_console_writer_tb: clean");
      end else begin
         $display("text_console_writer_tb: errors");
      end
      $finish;
   end

endmodule
